### hdl/ssg_pkg.sv
// Shared types, constants and helpers for the supply sag gain shaper.
// No dependencies. Every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package ssg_pkg;

  localparam int unsigned NumCh = 8;
  localparam int unsigned ChW   = $clog2(NumCh);
  localparam logic [23:0] OneQ23 = 24'h800000;
  localparam logic [23:0] MaxU24 = 24'hFFFFFF;

  // register indexes on the configuration port
  localparam logic [2:0] RegGain = 3'd0;
  localparam logic [2:0] RegAtt  = 3'd1;
  localparam logic [2:0] RegRel  = 3'd2;
  localparam logic [2:0] RegDis  = 3'd3;
  localparam logic [2:0] RegRec  = 3'd4;
  localparam logic [2:0] RegSep  = 3'd5;
  localparam logic [2:0] RegCnt  = 3'd6;

  typedef struct packed {
    logic [23:0] sensitivity_gain;
    logic [23:0] attack_coef;
    logic [23:0] release_coef;
    logic [31:0] discharge_coef;
    logic [31:0] recharge_coef;
    logic        separate_supplies;
    logic [3:0]  channels_in_use;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] sample_0;
    logic signed [23:0] sample_1;
    logic signed [23:0] sample_2;
    logic signed [23:0] sample_3;
    logic signed [23:0] sample_4;
    logic signed [23:0] sample_5;
    logic signed [23:0] sample_6;
    logic signed [23:0] sample_7;
  } in_t;

  typedef struct packed {
    logic signed [23:0] shaped_0;
    logic signed [23:0] shaped_1;
    logic signed [23:0] shaped_2;
    logic signed [23:0] shaped_3;
    logic signed [23:0] shaped_4;
    logic signed [23:0] shaped_5;
    logic signed [23:0] shaped_6;
    logic signed [23:0] shaped_7;
    logic [23:0]        peak_envelope;
    logic [23:0]        lowest_supply;
  } out_t;

  // magnitude of a Q1.23 sample; full-scale negative gives 0x800000
  function automatic logic [23:0] mag_of(input logic [23:0] s);
    mag_of = s[23] ? (~s + 24'd1) : s;
  endfunction

  // channel count as used by the datapath, 1..NumCh
  function automatic logic [3:0] eff_count(input logic [3:0] c);
    if (c == 4'd0) begin
      eff_count = 4'd1;
    end else if (c > 4'(NumCh)) begin
      eff_count = 4'(NumCh);
    end else begin
      eff_count = c;
    end
  endfunction

endpackage
`default_nettype wire

### hdl/supply_sag_gain_shaper_unit.sv
// Supply sag gain shaper: scales each active channel of a Q1.23 frame by a
// modelled amplifier supply voltage that sags with the signal envelope and
// recovers toward 1.0, per channel or shared across channels. A frame is
// taken only while the unit is idle and its result sits in an output
// register, so the next frame can be taken while that result waits. Timing
// is set by one shared 32x32 multiplier with a registered product and, in
// shared mode, by a bit-serial divide and square-root unit. Configuration
// sits on an APB port at byte address 4*index; write only while no frame is
// in flight. Depends on ssg_pkg, ssg_seq, ssg_root and ssg_mul.
`timescale 1ns / 1ps
`default_nettype none
module supply_sag_gain_shaper_unit
  import ssg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg_r, cfg_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;
  logic wr_en;
  logic seq_idle, res_load, slot_free, start;
  out_t res;

  assign pready    = 1'b1;
  assign wr_en     = psel & penable & pwrite & pready;
  assign in_ready  = seq_idle;
  assign start     = in_valid & in_ready;
  assign slot_free = ~out_valid_r | out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ssg_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (start),
    .frame     (in_data),
    .slot_free (slot_free),
    .idle      (seq_idle),
    .res_load  (res_load),
    .res       (res)
  );

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[4:2])
        RegGain: cfg_nxt.sensitivity_gain  = pwdata[23:0];
        RegAtt:  cfg_nxt.attack_coef       = pwdata[23:0];
        RegRel:  cfg_nxt.release_coef      = pwdata[23:0];
        RegDis:  cfg_nxt.discharge_coef    = pwdata;
        RegRec:  cfg_nxt.recharge_coef     = pwdata;
        RegSep:  cfg_nxt.separate_supplies = pwdata[0];
        RegCnt:  cfg_nxt.channels_in_use   = pwdata[3:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (paddr[4:2])
      RegGain: prdata = {8'd0, cfg_r.sensitivity_gain};
      RegAtt:  prdata = {8'd0, cfg_r.attack_coef};
      RegRel:  prdata = {8'd0, cfg_r.release_coef};
      RegDis:  prdata = cfg_r.discharge_coef;
      RegRec:  prdata = cfg_r.recharge_coef;
      RegSep:  prdata = {31'd0, cfg_r.separate_supplies};
      RegCnt:  prdata = {28'd0, cfg_r.channels_in_use};
      default: prdata = 32'd0;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensitivity_gain  <= 24'd65536;
      cfg_r.attack_coef       <= 24'd16431303;
      cfg_r.release_coef      <= 24'd16742303;
      cfg_r.discharge_coef    <= 32'd1771851;
      cfg_r.recharge_coef     <= 32'd984263;
      cfg_r.separate_supplies <= 1'b0;
      cfg_r.channels_in_use   <= 4'd2;
      out_valid_r             <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  // checks
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("frame taken while busy");

  a_supply_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.lowest_supply <= OneQ23)
    else $error("supply above full scale");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

### hdl/ssg_mul.sv
// Shared 32 x 32 unsigned multiplier with a registered product.
// Depends on ssg_pkg only by convention; used by the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module ssg_mul
  import ssg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [31:0] mul_a,
  input  wire logic [31:0] mul_b,
  output logic      [63:0] prod_r
);

  logic [63:0] prod_nxt;

  // one product per cycle
  assign prod_nxt = {32'd0, mul_a} * {32'd0, mul_b};

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule
`default_nettype wire

### hdl/ssg_root.sv
// Bit-serial unit: divides the sum of squared levels by the channel count,
// then takes the integer square root one digit per cycle. Uses ssg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssg_root
  import ssg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [50:0] dividend,
  input  wire logic [3:0]  divisor,
  output logic             done_r,
  output logic [23:0]      root
);

  typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} rstate_t;

  rstate_t     state_r, state_nxt;
  logic [50:0] q_r, q_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic [3:0]  div_r, div_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [47:0] x_r, x_nxt;
  logic [47:0] res_r, res_nxt;
  logic [47:0] bit_r, bit_nxt;
  logic        done_nxt;
  logic [4:0]  trial;
  logic        ge;
  logic [48:0] sq_sum;

  assign trial  = {rem_r, q_r[50]};
  assign ge     = trial >= {1'b0, div_r};
  assign sq_sum = {1'b0, res_r} + {1'b0, bit_r};
  assign root   = res_r[23:0];

  // restoring divide, then digit-by-digit square root
  always_comb begin
    state_nxt = state_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      R_IDLE: begin
        if (start) begin
          q_nxt     = dividend;
          div_nxt   = divisor;
          rem_nxt   = 4'd0;
          cnt_nxt   = 6'd50;
          state_nxt = R_DIV;
        end
      end
      R_DIV: begin
        rem_nxt = ge ? 4'(trial - {1'b0, div_r}) : trial[3:0];
        q_nxt   = {q_r[49:0], ge};
        if (cnt_r == 6'd0) begin
          x_nxt     = q_nxt[47:0];
          res_nxt   = 48'd0;
          bit_nxt   = 48'd1 << 46;
          cnt_nxt   = 6'd23;
          state_nxt = R_SQRT;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      R_SQRT: begin
        if ({1'b0, x_r} >= sq_sum) begin
          x_nxt   = 48'({1'b0, x_r} - sq_sum);
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (cnt_r == 6'd0) begin
          done_nxt  = 1'b1;
          state_nxt = R_IDLE;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      default: state_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

endmodule
`default_nettype wire

### hdl/ssg_seq.sv
// Sequencer of the shaper: holds envelope and supply state and steps the
// shared multiplier and the root unit through each frame. Uses ssg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssg_seq
  import ssg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic start,
  input  wire in_t  frame,
  input  wire logic slot_free,
  output logic      idle,
  output logic      res_load,
  output out_t      res
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_LVL_M, ST_LVL_U, ST_SQ_M, ST_SQ_U, ST_ROOT_GO, ST_ROOT_WAIT,
    ST_SM1_M, ST_SM1_U, ST_SM2_M, ST_SM2_U, ST_OE_M, ST_OE_U, ST_DR_M, ST_DR_U,
    ST_D1_M, ST_D1_U, ST_D2_M, ST_D2_U, ST_RC_M, ST_RC_U, ST_SH_M, ST_SH_U,
    ST_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic [23:0] smp_r [NumCh];
  logic [23:0] smp_nxt [NumCh];
  logic [23:0] sh_r [NumCh];
  logic [23:0] sh_nxt [NumCh];
  logic [23:0] env_mem_r [NumCh];
  logic [23:0] env_mem_nxt [NumCh];
  logic [23:0] sup_mem_r [NumCh];
  logic [23:0] sup_mem_nxt [NumCh];
  logic [23:0] com_env_r, com_env_nxt;
  logic [23:0] com_sup_r, com_sup_nxt;
  logic        seen_mode_r, seen_mode_nxt;
  logic [3:0]  seen_cnt_r, seen_cnt_nxt;
  logic        mode_r, mode_nxt;
  logic [3:0]  n_r, n_nxt;
  logic [ChW-1:0] ch_r, ch_nxt;
  logic [23:0] lvl_r, lvl_nxt;
  logic [23:0] c_r, c_nxt;
  logic [23:0] env_r, env_nxt;
  logic [23:0] oe_r, oe_nxt;
  logic [47:0] draw_r, draw_nxt;
  logic [80:0] acc_r, acc_nxt;
  logic [50:0] sum_r, sum_nxt;
  logic [23:0] vnew_r, vnew_nxt;
  logic [23:0] peak_r, peak_nxt;
  logic [23:0] low_r, low_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r;
  logic        root_start, root_done;
  logic [23:0] root;
  logic [23:0] env_old, v_old, mag_ch, c_sel, m_sh;
  logic [3:0]  n_in;
  logic        last_ch;
  logic [80:0] acc_sum;
  logic signed [41:0] nv;

  ssg_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  ssg_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .dividend (sum_r),
    .divisor  (n_r),
    .done_r   (root_done),
    .root     (root)
  );

  // per-step helpers
  assign env_old = mode_r ? env_mem_r[ch_r] : com_env_r;
  assign v_old   = mode_r ? sup_mem_r[ch_r] : com_sup_r;
  assign mag_ch  = mag_of(smp_r[ch_r]);
  assign c_sel   = (lvl_r > env_old) ? cfg.attack_coef : cfg.release_coef;
  assign n_in    = eff_count(cfg.channels_in_use);
  assign last_ch = ({1'b0, ch_r} == 4'(n_r - 4'd1));
  assign acc_sum = (state_r == ST_D2_U) ? acc_r + {prod_r[56:0], 24'd0}
                                        : acc_r + {17'd0, prod_r};
  assign m_sh    = prod_r[46:23];
  assign nv      = $signed({18'd0, v_old}) - $signed({2'd0, acc_r[80:41]})
                   + $signed({10'd0, prod_r[63:32]});
  assign idle    = (state_r == ST_IDLE);

  // result assembly
  assign res.shaped_0      = sh_r[0];
  assign res.shaped_1      = sh_r[1];
  assign res.shaped_2      = sh_r[2];
  assign res.shaped_3      = sh_r[3];
  assign res.shaped_4      = sh_r[4];
  assign res.shaped_5      = sh_r[5];
  assign res.shaped_6      = sh_r[6];
  assign res.shaped_7      = sh_r[7];
  assign res.peak_envelope = peak_r;
  assign res.lowest_supply = low_r;

  // next-state and datapath control
  always_comb begin
    state_nxt     = state_r;
    smp_nxt       = smp_r;
    sh_nxt        = sh_r;
    env_mem_nxt   = env_mem_r;
    sup_mem_nxt   = sup_mem_r;
    com_env_nxt   = com_env_r;
    com_sup_nxt   = com_sup_r;
    seen_mode_nxt = seen_mode_r;
    seen_cnt_nxt  = seen_cnt_r;
    mode_nxt      = mode_r;
    n_nxt         = n_r;
    ch_nxt        = ch_r;
    lvl_nxt       = lvl_r;
    c_nxt         = c_r;
    env_nxt       = env_r;
    oe_nxt        = oe_r;
    draw_nxt      = draw_r;
    acc_nxt       = acc_r;
    sum_nxt       = sum_r;
    vnew_nxt      = vnew_r;
    peak_nxt      = peak_r;
    low_nxt       = low_r;
    mul_a         = 32'd0;
    mul_b         = 32'd0;
    root_start    = 1'b0;
    res_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          smp_nxt[0] = frame.sample_0;
          smp_nxt[1] = frame.sample_1;
          smp_nxt[2] = frame.sample_2;
          smp_nxt[3] = frame.sample_3;
          smp_nxt[4] = frame.sample_4;
          smp_nxt[5] = frame.sample_5;
          smp_nxt[6] = frame.sample_6;
          smp_nxt[7] = frame.sample_7;
          mode_nxt   = cfg.separate_supplies;
          n_nxt      = n_in;
          // a change of mode or count restarts all supplies and envelopes
          if (cfg.separate_supplies != seen_mode_r || n_in != seen_cnt_r) begin
            for (int i = 0; i < NumCh; i++) begin
              env_mem_nxt[i] = 24'd0;
              sup_mem_nxt[i] = OneQ23;
            end
            com_env_nxt = 24'd0;
            com_sup_nxt = OneQ23;
          end
          seen_mode_nxt = cfg.separate_supplies;
          seen_cnt_nxt  = n_in;
          for (int i = 0; i < NumCh; i++) begin
            sh_nxt[i] = 24'd0;
          end
          peak_nxt  = 24'd0;
          low_nxt   = OneQ23;
          sum_nxt   = 51'd0;
          ch_nxt    = '0;
          state_nxt = ST_LVL_M;
        end
      end
      // detection level
      ST_LVL_M: begin
        mul_a     = {8'd0, mag_ch};
        mul_b     = {8'd0, cfg.sensitivity_gain};
        state_nxt = ST_LVL_U;
      end
      ST_LVL_U: begin
        lvl_nxt   = (prod_r[63:47] != 17'd0) ? MaxU24 : prod_r[46:23];
        state_nxt = mode_r ? ST_SM1_M : ST_SQ_M;
      end
      // sum of squares for the shared supply
      ST_SQ_M: begin
        mul_a     = {8'd0, lvl_r};
        mul_b     = {8'd0, lvl_r};
        state_nxt = ST_SQ_U;
      end
      ST_SQ_U: begin
        sum_nxt = sum_r + {3'd0, prod_r[47:0]};
        if (last_ch) begin
          state_nxt = ST_ROOT_GO;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = ST_LVL_M;
        end
      end
      ST_ROOT_GO: begin
        root_start = 1'b1;
        state_nxt  = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (root_done) begin
          lvl_nxt   = root;
          state_nxt = ST_SM1_M;
        end
      end
      // envelope smoothing
      ST_SM1_M: begin
        c_nxt     = c_sel;
        mul_a     = {8'd0, env_old};
        mul_b     = {8'd0, c_sel};
        state_nxt = ST_SM1_U;
      end
      ST_SM1_U: begin
        acc_nxt   = {17'd0, prod_r};
        state_nxt = ST_SM2_M;
      end
      ST_SM2_M: begin
        mul_a     = {8'd0, lvl_r};
        mul_b     = 32'(25'h1000000 - {1'b0, c_r});
        state_nxt = ST_SM2_U;
      end
      ST_SM2_U: begin
        env_nxt   = (acc_sum[80:48] != 33'd0) ? MaxU24 : acc_sum[47:24];
        state_nxt = ST_OE_M;
      end
      // current draw
      ST_OE_M: begin
        mul_a     = {8'd0, env_r};
        mul_b     = {8'd0, v_old};
        state_nxt = ST_OE_U;
      end
      ST_OE_U: begin
        oe_nxt    = prod_r[46:23];
        state_nxt = ST_DR_M;
      end
      ST_DR_M: begin
        mul_a     = {8'd0, oe_r};
        mul_b     = {8'd0, oe_r};
        state_nxt = ST_DR_U;
      end
      ST_DR_U: begin
        draw_nxt  = prod_r[47:0];
        state_nxt = ST_D1_M;
      end
      // discharge, in two partial products
      ST_D1_M: begin
        mul_a     = {8'd0, draw_r[23:0]};
        mul_b     = cfg.discharge_coef;
        state_nxt = ST_D1_U;
      end
      ST_D1_U: begin
        acc_nxt   = {17'd0, prod_r};
        state_nxt = ST_D2_M;
      end
      ST_D2_M: begin
        mul_a     = {8'd0, draw_r[47:24]};
        mul_b     = cfg.discharge_coef;
        state_nxt = ST_D2_U;
      end
      ST_D2_U: begin
        acc_nxt   = acc_sum;
        state_nxt = ST_RC_M;
      end
      // recharge and supply update
      ST_RC_M: begin
        mul_a     = {8'd0, OneQ23 - v_old};
        mul_b     = cfg.recharge_coef;
        state_nxt = ST_RC_U;
      end
      ST_RC_U: begin
        if (nv < 0) begin
          vnew_nxt = 24'd0;
        end else if (nv > $signed({18'd0, OneQ23})) begin
          vnew_nxt = OneQ23;
        end else begin
          vnew_nxt = nv[23:0];
        end
        if (mode_r) begin
          env_mem_nxt[ch_r] = env_r;
          sup_mem_nxt[ch_r] = vnew_nxt;
        end else begin
          com_env_nxt = env_r;
          com_sup_nxt = vnew_nxt;
          ch_nxt      = '0;
        end
        if (env_r > peak_r) begin
          peak_nxt = env_r;
        end
        if (vnew_nxt < low_r) begin
          low_nxt = vnew_nxt;
        end
        state_nxt = ST_SH_M;
      end
      // output shaping
      ST_SH_M: begin
        mul_a     = {8'd0, mag_ch};
        mul_b     = {8'd0, vnew_r};
        state_nxt = ST_SH_U;
      end
      ST_SH_U: begin
        sh_nxt[ch_r] = smp_r[ch_r][23] ? (~m_sh + 24'd1) : m_sh;
        if (last_ch) begin
          state_nxt = ST_DONE;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = mode_r ? ST_LVL_M : ST_SH_M;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seen_mode_r <= 1'b0;
      seen_cnt_r  <= 4'd2;
      com_env_r   <= 24'd0;
      com_sup_r   <= OneQ23;
      for (int i = 0; i < NumCh; i++) begin
        env_mem_r[i] <= 24'd0;
        sup_mem_r[i] <= OneQ23;
      end
    end else begin
      state_r     <= state_nxt;
      seen_mode_r <= seen_mode_nxt;
      seen_cnt_r  <= seen_cnt_nxt;
      com_env_r   <= com_env_nxt;
      com_sup_r   <= com_sup_nxt;
      env_mem_r   <= env_mem_nxt;
      sup_mem_r   <= sup_mem_nxt;
    end
    smp_r  <= smp_nxt;
    sh_r   <= sh_nxt;
    mode_r <= mode_nxt;
    n_r    <= n_nxt;
    ch_r   <= ch_nxt;
    lvl_r  <= lvl_nxt;
    c_r    <= c_nxt;
    env_r  <= env_nxt;
    oe_r   <= oe_nxt;
    draw_r <= draw_nxt;
    acc_r  <= acc_nxt;
    sum_r  <= sum_nxt;
    vnew_r <= vnew_nxt;
    peak_r <= peak_nxt;
    low_r  <= low_nxt;
  end

endmodule
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the supply sag gain shaper unit: frames are
// sent through a valid/ready driver and results are checked against a
// behavioural predictor. Depends on ssg_pkg and supply_sag_gain_shaper_unit.
`timescale 1ns / 1ps
module testbench;
  import ssg_pkg::*;

  localparam int unsigned WatchLimit = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  supply_sag_gain_shaper_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor configuration and state
  logic [23:0] gain_q, att_q, rel_q;
  logic [31:0] dis_q, rec_q;
  logic sep_q;
  logic [3:0] cnt_q;
  logic [23:0] ch_supply [NumCh];
  logic [23:0] ch_env [NumCh];
  logic [23:0] com_supply, com_env;
  logic last_mode;
  logic [3:0] last_count;

  in_t frame_queue[$];
  out_t shaped_queue[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_recv = 0;
  int unsigned errors = 0;
  int unsigned frames_sent = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;

  function automatic void clear_sag_state();
    for (int i = 0; i < NumCh; i++) begin
      ch_supply[i] = OneQ23;
      ch_env[i] = '0;
    end
    com_supply = OneQ23;
    com_env = '0;
  endfunction

  function automatic logic [23:0] level_of(logic [23:0] m);
    logic [63:0] p;
    p = (64'(m) * 64'(gain_q)) >> 23;
    return (p > 64'(MaxU24)) ? MaxU24 : p[23:0];
  endfunction

  function automatic logic [23:0] smooth_env(logic [23:0] env, logic [23:0] lvl);
    logic [63:0] c, s;
    c = (lvl > env) ? 64'(att_q) : 64'(rel_q);
    s = (64'(env) * c + 64'(lvl) * (64'h1000000 - c)) >> 24;
    return (s > 64'(MaxU24)) ? MaxU24 : s[23:0];
  endfunction

  function automatic logic [23:0] next_supply(logic [23:0] env, logic [23:0] v);
    logic [63:0] oe, drw, hi, lo, dis, rec;
    longint nv;
    oe = (64'(env) * 64'(v)) >> 23;
    drw = oe * oe;
    hi = drw * 64'(dis_q[31:16]);
    lo = drw * 64'(dis_q[15:0]);
    dis = (hi + (lo >> 16)) >> 25;
    rec = (64'(OneQ23 - v) * 64'(rec_q)) >> 32;
    nv = longint'(v) - longint'(dis) + longint'(rec);
    if (nv < 0) nv = 0;
    if (nv > longint'(OneQ23)) nv = longint'(OneQ23);
    return 24'(nv);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [23:0] shape_sample(logic [23:0] s, logic [23:0] v);
    logic [23:0] m;
    logic [63:0] p;
    m = s[23] ? 24'(-s) : s;
    p = (64'(m) * 64'(v)) >> 23;
    return s[23] ? 24'(-p[23:0]) : p[23:0];
  endfunction

  // works out the shaped frame and advances the sag state
  function automatic out_t shape_frame(in_t f);
    logic [23:0] smp [NumCh];
    logic [23:0] res [NumCh];
    logic [23:0] mg, env, v, peak, low;
    logic [63:0] sum, l;
    int unsigned n;
    out_t o;
    {smp[0], smp[1], smp[2], smp[3], smp[4], smp[5], smp[6], smp[7]} = f;
    n = (cnt_q == 0) ? 1 : ((cnt_q > NumCh) ? NumCh : cnt_q);
    if (sep_q != last_mode || 4'(n) != last_count) begin
      clear_sag_state();
      last_mode = sep_q;
      last_count = 4'(n);
    end
    peak = 0;
    low = OneQ23;
    sum = 0;
    for (int i = 0; i < NumCh; i++) res[i] = '0;
    if (sep_q) begin
      for (int i = 0; i < n; i++) begin
        mg = smp[i][23] ? 24'(-smp[i]) : smp[i];
        env = smooth_env(ch_env[i], level_of(mg));
        v = next_supply(env, ch_supply[i]);
        ch_env[i] = env;
        ch_supply[i] = v;
        if (env > peak) peak = env;
        if (v < low) low = v;
        res[i] = shape_sample(smp[i], v);
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        mg = smp[i][23] ? 24'(-smp[i]) : smp[i];
        l = 64'(level_of(mg));
        sum = sum + l * l;
      end
      env = smooth_env(com_env, 24'(int_sqrt(sum / n)));
      v = next_supply(env, com_supply);
      com_env = env;
      com_supply = v;
      peak = env;
      low = v;
      for (int i = 0; i < n; i++) res[i] = shape_sample(smp[i], v);
    end
    o = {res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7], peak, low};
    return o;
  endfunction

  // driver: presents queued frames, predicts on each transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        shaped_queue.push_back(shape_frame(in_data));
        frames_sent++;
      end
      if (!in_valid || in_ready) begin
        if (frame_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= frame_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer and paces the receiver
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (shaped_queue.size() == 0) begin
          $display("%0t unexpected result %h", $time, out_data);
          errors++;
        end else begin
          out_t want;
          want = shaped_queue.pop_front();
          if (want !== out_data) begin
            $display("%0t mismatch expected %h actual %h", $time, want, out_data);
            errors++;
          end
        end
      end
      if (hold_recv > 0) begin
        hold_recv <= hold_recv - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on transfer activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("[supply_sag_gain_shaper_unit] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegGain: gain_q = val[23:0];
      RegAtt:  att_q = val[23:0];
      RegRel:  rel_q = val[23:0];
      RegDis:  dis_q = val;
      RegRec:  rec_q = val;
      RegSep:  sep_q = val[0];
      RegCnt:  cnt_q = val[3:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (frame_queue.size() > 0 || in_valid || shaped_queue.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample(int unsigned kind);
    case (kind)
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'(($urandom_range(2000)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic in_t rand_frame(int unsigned loud);
    logic [23:0] s [NumCh];
    for (int i = 0; i < NumCh; i++)
      s[i] = loud ? rand_sample($urandom_range(3)) : rand_sample($urandom_range(2, 3));
    return {s[0], s[1], s[2], s[3], s[4], s[5], s[6], s[7]};
  endfunction

  task automatic random_block(input int unsigned count);
    for (int k = 0; k < count; k++) frame_queue.push_back(rand_frame($urandom_range(1)));
    wait_drained();
  endtask

  task automatic random_config(input bit extreme);
    write_reg(RegGain, extreme ? 32'hFFFFFF : 32'($urandom_range(32'h40000)));
    write_reg(RegAtt, extreme ? 32'd0 : 32'(24'($urandom) | 24'hF00000));
    write_reg(RegRel, extreme ? 32'hFFFFFF : 32'(24'($urandom) | 24'hF00000));
    write_reg(RegDis, extreme ? 32'hFFFFFFFF : $urandom);
    write_reg(RegRec, extreme ? 32'hFFFFFFFF : ($urandom >> $urandom_range(12)));
    write_reg(RegSep, 32'($urandom_range(1)));
    write_reg(RegCnt, 32'($urandom_range(15)));
  endtask

  // stimulus
  initial begin
    gain_q = 24'd65536;
    att_q = 24'd16431303;
    rel_q = 24'd16742303;
    dis_q = 32'd1771851;
    rec_q = 32'd984263;
    sep_q = 1'b0;
    cnt_q = 4'd2;
    last_mode = 1'b0;
    last_count = 4'd2;
    clear_sag_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, extremes, silence, all-ones patterns
    send_idle_pct = 28;
    recv_idle_pct = 86;
    frame_queue.push_back({8{24'h7FFFFF}});
    frame_queue.push_back({8{24'h800000}});
    frame_queue.push_back('0);
    frame_queue.push_back({8{24'hFFFFFF}});
    frame_queue.push_back({8{24'h000001}});
    wait_drained();
    write_reg(RegSep, 32'd1);
    write_reg(RegCnt, 32'd8);
    write_reg(RegGain, 32'hFFFFFF);
    write_reg(RegAtt, 32'd0);
    write_reg(RegDis, 32'hFFFFFFFF);
    for (int k = 0; k < 6; k++) frame_queue.push_back({8{24'h800000}});
    frame_queue.push_back('0);
    wait_drained();
    // count zero acts as one, above eight acts as eight
    write_reg(RegCnt, 32'd0);
    write_reg(RegSep, 32'd0);
    write_reg(RegRel, 32'd0);
    frame_queue.push_back({8{24'h7FFFFF}});
    wait_drained();
    write_reg(RegCnt, 32'd15);
    write_reg(RegRec, 32'hFFFFFFFF);
    frame_queue.push_back({8{24'h7FFFFF}});
    frame_queue.push_back('0);
    wait_drained();

    // random phases, idling swapped, then none
    for (int ph = 0; ph < 18; ph++) begin
      if (ph == 6) begin
        send_idle_pct = 86;
        recv_idle_pct = 28;
      end else if (ph == 12) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_config(ph == 3 || ph == 13);
      if (ph == 14) hold_recv = 3000;
      random_block(100);
    end
    wait_drained();
    $display("covered %0d frames and %0d results over 18 register settings",
             frames_sent, results_seen);
    if (errors == 0) begin
      $display("[supply_sag_gain_shaper_unit] OK");
    end else begin
      $display("[supply_sag_gain_shaper_unit] ERROR");
    end
    $finish;
  end

endmodule

### files.f
hdl/ssg_pkg.sv
hdl/ssg_mul.sv
hdl/ssg_root.sv
hdl/ssg_seq.sv
hdl/supply_sag_gain_shaper_unit.sv
sim/testbench.sv
